/* rtl/lfu_pkg.sv */
package lfu_pkg;

  localparam int unsigned CAP_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 32;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0]  MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] write_value;
  } lfu_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } lfu_result_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic sweep;
    logic decide;
  } lfu_cmd_t;

  typedef struct packed {
    logic need_sweep;
  } lfu_status_t;

endpackage

/* rtl/lfu_ctrl.sv */
module lfu_ctrl import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lfu_status_t   status_i,
  output logic          busy_o,
  output lfu_cmd_t      cmd_o,
  output logic [IW-1:0] addr_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_TAIL,
    S_DECIDE,
    S_SWEEP,
    S_SWEEP_TAIL
  } state_e;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_e        state_q;
  logic [IW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + IW'(1);
          if (cnt_q == LAST) begin
            state_q <= S_SCAN_TAIL;
          end
        end
        S_SCAN_TAIL: state_q <= S_DECIDE;
        S_DECIDE: begin
          cnt_q <= '0;
          if (status_i.need_sweep) begin
            state_q <= S_SWEEP;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SWEEP: begin
          cnt_q <= cnt_q + IW'(1);
          if (cnt_q == LAST) begin
            state_q <= S_SWEEP_TAIL;
          end
        end
        S_SWEEP_TAIL: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.rd_en  = (state_q == S_SCAN) || (state_q == S_SWEEP);
    cmd_o.sweep  = (state_q == S_SWEEP);
    cmd_o.decide = (state_q == S_DECIDE);
  end

  assign busy_o = (state_q != S_IDLE);
  assign addr_o = cnt_q;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("accepted beat did not start a scan");

  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (cnt_q <= LAST))
    else $error("entry address out of range");

  a_decide_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> ($past(state_q) == S_SCAN_TAIL))
    else $error("decide without a finished scan");
`endif

endmodule

/* rtl/lfu_dpath.sv */
module lfu_dpath import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  lfu_item_t        item_i,
  input  lfu_cmd_t         cmd_i,
  input  logic [IW-1:0]    addr_i,
  output lfu_status_t      status_o,
  output logic             result_valid_o,
  output lfu_result_t      result_o
);

  localparam int unsigned RW = IW;
  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = (UW > CAP_W) ? UW : CAP_W;

  logic [CAP_W-1:0]   capacity_q;
  lfu_item_t          item_q;
  logic [ENTRIES-1:0] valid_q;

  logic [DATA_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0]  data_mem [ENTRIES];
  logic [COUNT_W-1:0] cnt_mem  [ENTRIES];
  logic [RW-1:0]      rank_mem [ENTRIES];

  logic [DATA_W-1:0]  key_rd_q, data_rd_q;
  logic [COUNT_W-1:0] cnt_rd_q;
  logic [RW-1:0]      rank_rd_q;
  logic               pv_q, psweep_q;
  logic [IW-1:0]      pidx_q;
  logic               ent_vld;

  // scan results
  logic               found_q, free_q, vic_q;
  logic [UW-1:0]      used_q;
  logic [IW-1:0]      fidx_q, free_idx_q, vidx_q;
  logic [RW-1:0]      frank_q, vrank_q;
  logic [DATA_W-1:0]  fdata_q;
  logic [COUNT_W-1:0] fcnt_q, vcnt_q;

  // sweep plan
  logic [IW-1:0]      slot_q;
  logic [RW-1:0]      thr_q;
  logic               thr_all_q;

  logic               res_vld_q;
  lfu_result_t        res_q;

  // decision
  logic [XW-1:0]      cap_x, cap_eff, used_x;
  logic               full;
  logic               do_sweep, we_ent, thr_all_d;
  logic [IW-1:0]      slot_d;
  logic [RW-1:0]      thr_d;
  logic [DATA_W-1:0]  wdata;
  logic [COUNT_W-1:0] wcnt;
  lfu_result_t        res_d;
  logic               take_vic;

  assign ent_vld = valid_q[pidx_q];

  assign take_vic = !vic_q || (cnt_rd_q < vcnt_q) ||
                    ((cnt_rd_q == vcnt_q) && (rank_rd_q > vrank_q));

  always_comb begin
    cap_x   = XW'(capacity_q);
    cap_eff = (cap_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cap_x;
    used_x  = XW'(used_q);
    full    = (used_x >= cap_eff) || !free_q;

    do_sweep  = 1'b0;
    we_ent    = 1'b0;
    thr_all_d = 1'b0;
    slot_d    = fidx_q;
    thr_d     = frank_q;
    wdata     = item_q.write_value;
    wcnt      = COUNT_W'(1);
    res_d.hit        = found_q;
    res_d.read_value = '0;

    if (found_q) begin
      do_sweep = 1'b1;
      we_ent   = 1'b1;
      wcnt     = (fcnt_q == COUNT_MAX) ? fcnt_q : fcnt_q + COUNT_W'(1);
      if (item_q.mode == MODE_GET) begin
        wdata            = fdata_q;
        res_d.read_value = fdata_q;
      end
    end else if (item_q.mode == MODE_GET) begin
      res_d.read_value = MISS_VALUE;
    end else if (capacity_q != '0) begin
      if (full) begin
        if (vic_q) begin
          do_sweep = 1'b1;
          we_ent   = 1'b1;
          slot_d   = vidx_q;
          thr_d    = vrank_q;
        end
      end else begin
        do_sweep  = 1'b1;
        we_ent    = 1'b1;
        slot_d    = free_idx_q;
        thr_all_d = 1'b1;
      end
    end
  end

  assign status_o.need_sweep = do_sweep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      valid_q    <= '0;
      pv_q       <= 1'b0;
      psweep_q   <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      vic_q      <= 1'b0;
      used_q     <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      pv_q      <= cmd_i.rd_en;
      psweep_q  <= cmd_i.sweep;
      res_vld_q <= cmd_i.decide;
      if (cmd_i.load) begin
        found_q <= 1'b0;
        free_q  <= 1'b0;
        vic_q   <= 1'b0;
        used_q  <= '0;
      end else if (pv_q && !psweep_q) begin
        if (ent_vld) begin
          used_q <= used_q + UW'(1);
          if (key_rd_q == item_q.key) begin
            found_q <= 1'b1;
          end
          if (take_vic) begin
            vic_q <= 1'b1;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.decide && we_ent) begin
        valid_q[slot_d] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.rd_en) begin
      key_rd_q  <= key_mem[addr_i];
      data_rd_q <= data_mem[addr_i];
      cnt_rd_q  <= cnt_mem[addr_i];
      rank_rd_q <= rank_mem[addr_i];
      pidx_q    <= addr_i;
    end
    if (pv_q && !psweep_q) begin
      if (ent_vld) begin
        if (key_rd_q == item_q.key) begin
          fidx_q  <= pidx_q;
          frank_q <= rank_rd_q;
          fdata_q <= data_rd_q;
          fcnt_q  <= cnt_rd_q;
        end
        if (take_vic) begin
          vidx_q  <= pidx_q;
          vcnt_q  <= cnt_rd_q;
          vrank_q <= rank_rd_q;
        end
      end else if (!free_q) begin
        free_idx_q <= pidx_q;
      end
    end
    if (cmd_i.decide) begin
      slot_q    <= slot_d;
      thr_q     <= thr_d;
      thr_all_q <= thr_all_d;
      res_q     <= res_d;
      if (we_ent) begin
        key_mem[slot_d]  <= item_q.key;
        data_mem[slot_d] <= wdata;
        cnt_mem[slot_d]  <= wcnt;
      end
    end
    if (pv_q && psweep_q) begin
      if (pidx_q == slot_q) begin
        rank_mem[pidx_q] <= '0;
      end else if (ent_vld && (thr_all_q || (rank_rd_q < thr_q))) begin
        rank_mem[pidx_q] <= rank_rd_q + RW'(1);
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef ASSERT_OFF
  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && !found_q && item_q.mode == MODE_PUT && capacity_q != '0 && full)
    |-> vic_q)
    else $error("eviction needed but no victim found");

  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> ($countones(valid_q) == int'(used_q)))
    else $error("scan occupancy disagrees with valid bits");

  a_valid_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("valid entry lost");

  a_result_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(cmd_i.decide))
    else $error("result beat without a decision");
`endif

endmodule

/* rtl/lfu_cache_replacement_top.sv */
// Channel  | Direction | Handshake                 | Payload
// config   | in        | cfg_we_i                  | cfg_wdata_i (capacity)
// item     | in        | start_i high, busy_o low  | item_i (mode, key, write_value)
// result   | out       | result_valid_o, 1 cycle   | result_o (hit, read_value)
//
// Each item scans all ENTRIES slots through the registered memory read port,
// one slot per cycle, then decides. Hits and inserts add a second pass that
// rewrites the recency ranks one slot per cycle; no new item is taken until
// the item is done. Get misses and ignored puts skip the second pass. The
// result beat comes in the cycle after the decision. Reset clears the valid
// bits at once; no clearing pass. The receiver cannot stall.
module lfu_cache_replacement_top import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             start_i,
  input  lfu_item_t        item_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output lfu_result_t      result_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  lfu_cmd_t      cmd;
  lfu_status_t   status;
  logic [IW-1:0] addr;

  lfu_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .addr_o  (addr)
  );

  lfu_dpath #(
    .ENTRIES(ENTRIES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .status_o      (status),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule
